FILE: hw/rtl/bda_pkg.sv
// bda_pkg: shared widths, constants and types for the binary to decimal ascii block
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package bda_pkg;

    // input value and output character widths
    localparam int VALUE_W = 16;
    localparam int ASCII_W = 6;
    localparam int DIGIT_W = 4;

    // number of characters sent per value
    localparam int DIGIT_COUNT = 5;

    // a 16-bit value has at most five decimal digits
    localparam int MAX_DIGITS = 5;

    // digits actually produced by the divider, the rest are always zero
    localparam int CONV_STEPS = (DIGIT_COUNT < MAX_DIGITS) ? DIGIT_COUNT : MAX_DIGITS;
    localparam int STEP_W = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;
    localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int BCD_W = DIGIT_W * CONV_STEPS;

    // divide by ten: q = (x * 0xCCCD) >> 19, exact for every 16-bit x
    localparam int PROD_W = 2 * VALUE_W;
    localparam logic [VALUE_W-1:0] RECIP_TEN = 16'hCCCD;
    localparam int RECIP_SHIFT = 19;

    // ascii code of the character zero
    localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;

    // queue between the converter and the character sender
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // packed decimal digits, least significant digit in the low nibble
    typedef logic [BCD_W-1:0] bcd_t;

    // queue fill status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } bda_q_stat_t;

endpackage

FILE: hw/rtl/binary_to_decimal_ascii.sv
// Binary to decimal ascii converter. Each accepted 16-bit value comes out as five
// ascii characters '0' to '9', most significant digit first, leading zeros kept,
// with m_last_digit set on the least significant one. The converter does one
// divide by ten per cycle, by reciprocal multiply, and the character sender
// sends one character per cycle while the output is not stalled. Once busy, the
// converter takes a new value only in the cycle that it pushes the digits of the
// last one; that push waits while the queue is full. A two-entry queue between
// converter and sender lets the input side go on while results wait.
// depends on bda_pkg, bda_front, bda_queue, bda_back
`timescale 1ns / 1ps

module binary_to_decimal_ascii import bda_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ASCII_W-1:0] m_ascii_digit,
    output logic               m_last_digit
);

    bda_q_stat_t q_stat;
    logic        push;
    bcd_t        push_data;
    logic        pop;
    bcd_t        pop_data;

    // converter
    bda_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // digit set queue
    bda_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // character sender
    bda_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .pop_data      (pop_data),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_digit (m_ascii_digit),
        .m_last_digit  (m_last_digit)
    );

endmodule

FILE: hw/rtl/bda_front.sv
// bda_front: accepts values and converts them to packed decimal digits
// one divide by ten per cycle, the last waiting for room in the queue; depends on bda_pkg
`timescale 1ns / 1ps

module bda_front import bda_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  bda_q_stat_t        q_stat,
    output logic               push,
    output bcd_t               push_data
);

    logic               busy_reg, busy_next;
    logic [VALUE_W-1:0] rest_reg, rest_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    bcd_t               bcd_reg, bcd_next;

    logic [PROD_W-1:0]  prod;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] digit;
    logic [BCD_W+DIGIT_W-1:0] cat;
    bcd_t               shifted;
    logic               final_step;
    logic               accept;

    // quotient by reciprocal multiply, remainder from the low bits
    always_comb begin
        prod    = PROD_W'(rest_reg) * PROD_W'(RECIP_TEN);
        quot    = VALUE_W'(prod >> RECIP_SHIFT);
        digit   = rest_reg[DIGIT_W-1:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};
        cat     = {digit, bcd_reg};
        shifted = cat[BCD_W+DIGIT_W-1:DIGIT_W];
    end

    // handshake with the input and the queue
    assign final_step = busy_reg && (step_reg == STEP_W'(CONV_STEPS - 1));
    assign push       = final_step && !q_stat.full;
    assign push_data  = shifted;
    assign s_ready    = !busy_reg || push;
    assign accept     = s_valid && s_ready;

    // converter sequencing
    always_comb begin
        busy_next = busy_reg;
        rest_next = rest_reg;
        step_next = step_reg;
        bcd_next  = bcd_reg;
        if (busy_reg && !final_step) begin
            rest_next = quot;
            bcd_next  = shifted;
            step_next = step_reg + STEP_W'(1);
        end
        if (push) begin
            busy_next = 1'b0;
        end
        if (accept) begin
            busy_next = 1'b1;
            rest_next = s_value;
            step_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        rest_reg <= rest_next;
        step_reg <= step_next;
        bcd_reg  <= bcd_next;
    end

endmodule

FILE: hw/rtl/bda_queue.sv
// bda_queue: short fifo of converted digit sets between front and back
// depends on bda_pkg
`timescale 1ns / 1ps

module bda_queue import bda_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bcd_t        push_data,
    input  logic        pop,
    output bcd_t        pop_data,
    output bda_q_stat_t q_stat
);

    bcd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // status and read side
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage write
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/bda_back.sv
// bda_back: sends the digits of one set as ascii characters, most significant first
// registered output stage; depends on bda_pkg
`timescale 1ns / 1ps

module bda_back import bda_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  bda_q_stat_t        q_stat,
    input  bcd_t               pop_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ASCII_W-1:0] m_ascii_digit,
    output logic               m_last_digit
);

    logic               ent_valid_reg, ent_valid_next;
    bcd_t               ent_reg, ent_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [ASCII_W-1:0] m_ascii_reg, m_ascii_next;
    logic               m_last_reg, m_last_next;

    logic               out_free;
    logic               emit;
    logic               ent_done;
    logic [DIGIT_W-1:0] sel_digit;

    // output stage control
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = ent_valid_reg && out_free;
    assign ent_done = emit && (pos_reg == '0);
    assign pop      = !q_stat.empty && (!ent_valid_reg || ent_done);

    // digit at the current position, positions above the converted ones read zero
    always_comb begin
        sel_digit = '0;
        for (int i = 0; i < CONV_STEPS; i++) begin
            if (pos_reg == POS_W'(i)) begin
                sel_digit = ent_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // next state of the sender
    always_comb begin
        ent_valid_next = ent_valid_reg;
        ent_next       = ent_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg;
        m_ascii_next   = m_ascii_reg;
        m_last_next    = m_last_reg;
        if (out_free) begin
            m_valid_next = emit;
        end
        if (emit) begin
            m_ascii_next = ASCII_ZERO + ASCII_W'(sel_digit);
            m_last_next  = (pos_reg == '0);
            pos_next     = pos_reg - POS_W'(1);
        end
        if (ent_done) begin
            ent_valid_next = 1'b0;
        end
        if (pop) begin
            ent_valid_next = 1'b1;
            ent_next       = pop_data;
            pos_next       = POS_W'(DIGIT_COUNT - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            ent_valid_reg <= ent_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg     <= ent_next;
        pos_reg     <= pos_next;
        m_ascii_reg <= m_ascii_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_ascii_digit = m_ascii_reg;
    assign m_last_digit  = m_last_reg;

endmodule

FILE: hw/rtl/bda_checker.sv
// bda_checker: port level assertions for binary_to_decimal_ascii, with its bind
// depends on bda_pkg and the top level ports
`timescale 1ns / 1ps

module bda_checker import bda_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [VALUE_W-1:0] s_value,
    input logic               m_valid,
    input logic               m_ready,
    input logic [ASCII_W-1:0] m_ascii_digit,
    input logic               m_last_digit
);

    localparam int PEND_W = 4;

    logic [POS_W-1:0]  char_cnt_reg;
    logic [PEND_W-1:0] pend_reg;
    logic              in_xfer;
    logic              out_xfer;
    logic              out_last_xfer;
    logic [VALUE_W-1:0] value_seen;

    assign in_xfer       = s_valid && s_ready;
    assign out_xfer      = m_valid && m_ready;
    assign out_last_xfer = out_xfer && m_last_digit;
    assign value_seen    = s_value;

    // characters sent in the current run and values not yet fully sent
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_cnt_reg <= '0;
            pend_reg     <= '0;
        end else begin
            if (out_xfer) begin
                char_cnt_reg <= m_last_digit ? '0 : char_cnt_reg + POS_W'(1);
            end
            pend_reg <= pend_reg + PEND_W'(in_xfer) - PEND_W'(out_last_xfer);
        end
    end

    // a stalled character holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ascii_digit) && $stable(m_last_digit))
        else $error("output character changed while stalled");

    // last flag on exactly every run's final character
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> (m_last_digit == (char_cnt_reg == POS_W'(DIGIT_COUNT - 1))))
        else $error("last flag out of place");

    // no run ends without a value taken for it
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        out_last_xfer |-> (pend_reg != '0) || in_xfer || $past(in_xfer))
        else $error("run sent without a value");

    // only decimal digit characters
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_ascii_digit >= ASCII_ZERO) && (m_ascii_digit <= ASCII_ZERO + 6'd9)
                    && (value_seen == s_value))
        else $error("character outside '0' to '9'");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (.*);

FILE: verif/binary_to_decimal_ascii_test.sv
// binary_to_decimal_ascii_test: self-checking bench for the binary to decimal ascii block
// predicts the five digit characters of every value and compares each result transfer
// depends on bda_pkg and binary_to_decimal_ascii
`timescale 1ns / 1ps

module binary_to_decimal_ascii_test;
    import bda_pkg::*;

    localparam int DECIMAL_BASE = 10;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_VALUES = 300;
    localparam int STALL_VALUES = 24;
    localparam int PAUSE_BATCHES = 2;
    localparam int PAUSE_BATCH_VALUES = 8;
    localparam int STREAM_VALUES = 24;
    localparam int LONG_HOLD_CYCLES = 150;

    // one expected character
    typedef struct {
        logic [ASCII_W-1:0] ascii;
        logic               last;
    } digit_char_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [ASCII_W-1:0] m_ascii_digit;
    logic               m_last_digit;

    digit_char_t digits_due[$];
    int          fail_count = 0;
    bit          no_gaps = 1'b0;
    int          hold_len = 0;
    bit          hold_active = 1'b0;

    binary_to_decimal_ascii dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_digit (m_ascii_digit),
        .m_last_digit  (m_last_digit)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps) return 0;
        if (roll < 40) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // decimal digits of a value, most significant first, last flag on the final one
    task automatic queue_decimal_digits(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] rest;
        digit_char_t        row [DIGIT_COUNT];
        rest = value;
        for (int k = DIGIT_COUNT - 1; k >= 0; k--) begin
            row[k].ascii = ASCII_ZERO + ASCII_W'(rest % DECIMAL_BASE);
            row[k].last  = (k == DIGIT_COUNT - 1);
            rest = rest / DECIMAL_BASE;
        end
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            digits_due.push_back(row[k]);
        end
    endtask

    // offer one value after a random gap, record its digits once the transfer happens
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) begin
                s_value <= VALUE_W'($urandom);
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        queue_decimal_digits(value);
    endtask

    // drop valid before the sender waits on anything else
    task automatic release_input();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        release_input();
        while (digits_due.size() != 0) @(posedge aclk);
    endtask

    task automatic report_field(input string field, input int want, input int got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, field, want, got);
        end
    endtask

    // receiver: random ready pattern, or a long hold when a test asks for one
    initial begin
        int gap;
        m_ready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_len != 0) begin
                m_ready <= 1'b0;
                hold_active = 1'b1;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
                hold_active = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    end

    // compare each result transfer with the oldest expected character
    always @(posedge aclk) begin
        digit_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digits_due.size() == 0) begin
                report_field("unexpected character", -1, m_ascii_digit);
            end else begin
                want = digits_due.pop_front();
                if (m_ascii_digit !== want.ascii) begin
                    report_field("ascii_digit", want.ascii, m_ascii_digit);
                end
                if (m_last_digit !== want.last) begin
                    report_field("last_digit", want.last, m_last_digit);
                end
            end
        end
    end

    // field extremes, powers of ten and their neighbors, alternating bit patterns
    task automatic test_directed_values();
        logic [VALUE_W-1:0] picks [$];
        picks = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd999,
                  16'd1000, 16'd9999, 16'd10000, 16'd12345, 16'd54321, 16'd32767,
                  16'd32768, 16'hAAAA, 16'h5555, 16'd59999, 16'd60000, 16'd65534,
                  16'd65535};
        foreach (picks[i]) send_value(picks[i]);
    endtask

    // random mix: small numbers, values around powers of ten, full range
    task automatic test_random_values();
        logic [VALUE_W-1:0] value;
        int                 base;
        for (int i = 0; i < RANDOM_VALUES; i++) begin
            case ($urandom_range(0, 3))
                0: value = VALUE_W'($urandom_range(0, 99));
                1: begin
                    case ($urandom_range(0, 3))
                        0: base = 10;
                        1: base = 100;
                        2: base = 1000;
                        default: base = 10000;
                    endcase
                    value = VALUE_W'(base + $urandom_range(0, 4) - 2);
                end
                default: value = VALUE_W'($urandom);
            endcase
            send_value(value);
        end
    endtask

    // receiver holds off while values keep coming, so the block stalls its input
    task automatic test_output_stall();
        release_input();
        no_gaps = 1'b1;
        hold_len = LONG_HOLD_CYCLES;
        wait (hold_active);
        for (int i = 0; i < STALL_VALUES; i++) send_value(VALUE_W'($urandom));
        no_gaps = 1'b0;
    endtask

    // sender waits for every character before the next batch
    task automatic test_sender_pause();
        for (int b = 0; b < PAUSE_BATCHES; b++) begin
            wait_drained();
            for (int i = 0; i < PAUSE_BATCH_VALUES; i++) send_value(VALUE_W'($urandom));
        end
    endtask

    // back to back values with no idling on the input side
    task automatic test_continuous_stream();
        no_gaps = 1'b1;
        for (int i = 0; i < STREAM_VALUES; i++) send_value(VALUE_W'($urandom));
        no_gaps = 1'b0;
    endtask

    // test sequence
    initial begin
        s_valid <= 1'b0;
        s_value <= '0;
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_values();
        test_random_values();
        test_output_stall();
        test_sender_pause();
        test_continuous_stream();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: binary_to_decimal_ascii.f
hw/rtl/bda_pkg.sv
hw/rtl/bda_front.sv
hw/rtl/bda_queue.sv
hw/rtl/bda_back.sv
hw/rtl/binary_to_decimal_ascii.sv
hw/rtl/bda_checker.sv
verif/binary_to_decimal_ascii_test.sv
